// ===== rtl/arh_pkg.sv =====
// Shared constants for the axis-aligned rectangle ray hit core.
package arh_pkg;

	// plane axis codes
	localparam logic [1:0] AXIS_XY = 2'd0;
	localparam logic [1:0] AXIS_YZ = 2'd1;
	localparam logic [1:0] AXIS_XZ = 2'd2;

	// register indexes on the configuration port
	localparam logic [2:0] REG_AXIS        = 3'd0;
	localparam logic [2:0] REG_OFFSET      = 3'd1;
	localparam logic [2:0] REG_FIRST_LOW   = 3'd2;
	localparam logic [2:0] REG_FIRST_HIGH  = 3'd3;
	localparam logic [2:0] REG_SECOND_LOW  = 3'd4;
	localparam logic [2:0] REG_SECOND_HIGH = 3'd5;

endpackage

// ===== rtl/arh_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
module arh_div #(
	parameter int NUM_W = 49,
	parameter int DEN_W = 32,
	parameter type payload_t = logic
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  payload_t         in_pay,
	output logic             out_valid,
	output logic [NUM_W-1:0] quo,
	output payload_t         out_pay
);

	// stage registers: dividend bits shift out on top, quotient bits shift in below
	logic [NUM_W-1:0] vld_s;
	logic [NUM_W-1:0] nq_s  [NUM_W];
	logic [DEN_W-1:0] rem_s [NUM_W];
	logic [DEN_W-1:0] den_s [NUM_W];
	payload_t         pay_s [NUM_W];

	logic [NUM_W-1:0] vld_in;
	logic [NUM_W-1:0] nq_in  [NUM_W];
	logic [DEN_W-1:0] rem_in [NUM_W];
	logic [DEN_W-1:0] den_in [NUM_W];
	payload_t         pay_in [NUM_W];
	logic [NUM_W-1:0] nq_nx  [NUM_W];
	logic [DEN_W-1:0] rem_nx [NUM_W];

	// per-stage trial subtract
	always_comb begin
		logic [DEN_W:0] trial;
		logic           ge;
		for (int k = 0; k < NUM_W; k++) begin
			if (k == 0) begin
				vld_in[k] = in_valid;
				nq_in[k]  = num;
				rem_in[k] = '0;
				den_in[k] = den;
				pay_in[k] = in_pay;
			end else begin
				vld_in[k] = vld_s[k-1];
				nq_in[k]  = nq_s[k-1];
				rem_in[k] = rem_s[k-1];
				den_in[k] = den_s[k-1];
				pay_in[k] = pay_s[k-1];
			end
			trial = {rem_in[k], nq_in[k][NUM_W-1]};
			ge = trial >= {1'b0, den_in[k]};
			nq_nx[k] = {nq_in[k][NUM_W-2:0], ge};
			rem_nx[k] = ge ? DEN_W'(trial - {1'b0, den_in[k]}) : trial[DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NUM_W; k++) begin
				nq_s[k]  <= nq_nx[k];
				rem_s[k] <= rem_nx[k];
				den_s[k] <= den_in[k];
				pay_s[k] <= pay_in[k];
			end
		end
	end

	assign out_valid = vld_s[NUM_W-1];
	assign quo       = nq_s[NUM_W-1];
	assign out_pay   = pay_s[NUM_W-1];

endmodule

// ===== rtl/axis_aligned_rect_ray_hit_core.sv =====
// Top level of the ray against axis-aligned rectangle intersection core.
//
// Takes one ray per cycle, unless held as below, and returns one result per ray,
// in order; coordinates are Q16.16 by default. Rays pass two bit-per-stage
// divider pipelines: one for the hit parameter t, then one pair for u/v.
// The whole pipeline advances together and holds while the output register is
// full and not taken. Miss results carry all-zero fields. Configuration registers
// are read live and should be written only while no ray is in flight.
module axis_aligned_rect_ray_hit_core
	import arh_pkg::*;
#(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// ray input: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_near, t_far
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [((8*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	// result: t_hit, u_coord, v_coord, point_x, point_y, point_z
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [((4*COORD_WIDTH+2*(FRAC_BITS+1)+7)/8)*8-1:0] m_tdata,
	// result flags: hit, front_facing
	output logic [1:0]  m_tuser
);

	localparam int CW     = COORD_WIDTH;
	localparam int F      = FRAC_BITS;
	localparam int UV_W   = F + 1;
	localparam int OUT_W  = ((4*CW+2*UV_W+7)/8)*8;
	localparam int TQ_W   = CW + 1 + F;
	localparam int UQ_W   = CW + F;
	localparam int PW     = 2*CW - F + 1;

	typedef struct packed {
		logic signed [CW-1:0] ox;
		logic signed [CW-1:0] oy;
		logic signed [CW-1:0] oz;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [CW-1:0] dz;
		logic signed [CW-1:0] tn;
		logic signed [CW-1:0] tf;
	} ray_t;

	typedef struct packed {
		ray_t ray;
		logic qneg;
		logic dzero;
		logic front;
	} tdiv_pay_t;

	typedef struct packed {
		logic          hit;
		logic [CW-1:0] t;
		logic [CW-1:0] px;
		logic [CW-1:0] py;
		logic [CW-1:0] pz;
		logic          front;
		logic          pos_a;
	} udiv_pay_t;

	// configuration registers
	logic [1:0]           axis_q;
	logic signed [CW-1:0] offset_q, first_low_q, first_high_q, second_low_q, second_high_q;
	logic [2:0]           reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q        <= AXIS_XY;
			offset_q      <= '0;
			first_low_q   <= '0;
			first_high_q  <= '0;
			second_low_q  <= '0;
			second_high_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_AXIS:        axis_q        <= pwdata[1:0];
				REG_OFFSET:      offset_q      <= pwdata[CW-1:0];
				REG_FIRST_LOW:   first_low_q   <= pwdata[CW-1:0];
				REG_FIRST_HIGH:  first_high_q  <= pwdata[CW-1:0];
				REG_SECOND_LOW:  second_low_q  <= pwdata[CW-1:0];
				REG_SECOND_HIGH: second_high_q <= pwdata[CW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_AXIS:        prdata = 32'(axis_q);
			REG_OFFSET:      prdata = 32'(offset_q);
			REG_FIRST_LOW:   prdata = 32'(first_low_q);
			REG_FIRST_HIGH:  prdata = 32'(first_high_q);
			REG_SECOND_LOW:  prdata = 32'(second_low_q);
			REG_SECOND_HIGH: prdata = 32'(second_high_q);
			default:         prdata = '0;
		endcase
	end

	// global advance: everything moves unless the output holds an untaken result
	logic adv;
	logic vld_s7;
	assign adv      = !vld_s7 || m_tready;
	assign s_tready = adv;

	// stage 1: unpack, pick normal axis, offset minus origin
	ray_t                 ray_in;
	logic signed [CW-1:0] on_c, dn_c;

	assign ray_in = '{ox: s_tdata[0*CW +: CW], oy: s_tdata[1*CW +: CW],
		oz: s_tdata[2*CW +: CW], dx: s_tdata[3*CW +: CW], dy: s_tdata[4*CW +: CW],
		dz: s_tdata[5*CW +: CW], tn: s_tdata[6*CW +: CW], tf: s_tdata[7*CW +: CW]};

	always_comb begin
		case (axis_q)
			AXIS_YZ: begin on_c = ray_in.ox; dn_c = ray_in.dx; end
			AXIS_XZ: begin on_c = ray_in.oy; dn_c = ray_in.dy; end
			default: begin on_c = ray_in.oz; dn_c = ray_in.dz; end
		endcase
	end

	logic                 vld_s1;
	logic signed [CW:0]   diff_s1;
	logic signed [CW-1:0] dn_s1;
	ray_t                 ray_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			diff_s1 <= (CW+1)'(offset_q) - (CW+1)'(on_c);
			dn_s1   <= dn_c;
			ray_s1  <= ray_in;
		end
	end

	// stage 2: magnitudes and quotient sign
	logic          vld_s2;
	logic [CW:0]   nmag_s2;
	logic [CW-1:0] dmag_s2;
	tdiv_pay_t     tpay_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nmag_s2       <= diff_s1[CW] ? (CW+1)'(-diff_s1) : diff_s1;
			dmag_s2       <= dn_s1[CW-1] ? CW'(-dn_s1) : dn_s1;
			tpay_s2.ray   <= ray_s1;
			tpay_s2.qneg  <= diff_s1[CW] ^ dn_s1[CW-1];
			tpay_s2.dzero <= (dn_s1 == '0);
			tpay_s2.front <= dn_s1[CW-1];
		end
	end

	// t divider
	logic            tdiv_vld;
	logic [TQ_W-1:0] tq;
	tdiv_pay_t       tdiv_pay;

	arh_div #(.NUM_W(TQ_W), .DEN_W(CW), .payload_t(tdiv_pay_t)) u_tdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s2),
		.num       ({nmag_s2, {F{1'b0}}}),
		.den       (dmag_s2),
		.in_pay    (tpay_s2),
		.out_valid (tdiv_vld),
		.quo       (tq),
		.out_pay   (tdiv_pay)
	);

	// stage 3: signed t and interval test
	logic signed [TQ_W:0] t_mag, t_full;
	assign t_mag  = {1'b0, tq};
	assign t_full = tdiv_pay.qneg ? -t_mag : t_mag;

	logic                 vld_s3, ok_s3, front_s3;
	logic signed [CW-1:0] t_s3;
	ray_t                 ray_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (adv) vld_s3 <= tdiv_vld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s3    <= !tdiv_pay.dzero && (t_full >= (TQ_W+1)'(tdiv_pay.ray.tn))
				&& (t_full <= (TQ_W+1)'(tdiv_pay.ray.tf));
			front_s3 <= tdiv_pay.front;
			t_s3     <= t_full[CW-1:0];
			ray_s3   <= tdiv_pay.ray;
		end
	end

	// stage 4: t times each direction component
	logic                   vld_s4, ok_s4, front_s4;
	logic signed [CW-1:0]   t_s4, ox_s4, oy_s4, oz_s4;
	logic signed [2*CW-1:0] prx_s4, pry_s4, prz_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (adv) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prx_s4   <= t_s3 * ray_s3.dx;
			pry_s4   <= t_s3 * ray_s3.dy;
			prz_s4   <= t_s3 * ray_s3.dz;
			ox_s4    <= ray_s3.ox;
			oy_s4    <= ray_s3.oy;
			oz_s4    <= ray_s3.oz;
			t_s4     <= t_s3;
			ok_s4    <= ok_s3;
			front_s4 <= front_s3;
		end
	end

	// stage 5: hit point, product floored by the fraction shift
	logic                 vld_s5, ok_s5, front_s5;
	logic signed [CW-1:0] t_s5;
	logic signed [PW-1:0] px_s5, py_s5, pz_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (adv) vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s5    <= PW'(ox_s4) + PW'($signed(prx_s4[2*CW-1:F]));
			py_s5    <= PW'(oy_s4) + PW'($signed(pry_s4[2*CW-1:F]));
			pz_s5    <= PW'(oz_s4) + PW'($signed(prz_s4[2*CW-1:F]));
			t_s5     <= t_s4;
			ok_s5    <= ok_s4;
			front_s5 <= front_s4;
		end
	end

	// stage 6: bounds test, offsets into the rectangle, saturated point
	function automatic logic [CW-1:0] sat(input logic signed [PW-1:0] p);
		logic [PW-CW:0] top;
		top = p[PW-1:CW-1];
		if (top == '0 || top == '1) return p[CW-1:0];
		return p[PW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
	endfunction

	logic signed [PW-1:0] pa_c, pb_c, ra_c, rb_c;
	logic signed [CW:0]   span_a_c, span_b_c;
	logic                 in_a_c, in_b_c;

	always_comb begin
		case (axis_q)
			AXIS_YZ: begin pa_c = py_s5; pb_c = pz_s5; end
			AXIS_XZ: begin pa_c = px_s5; pb_c = pz_s5; end
			default: begin pa_c = px_s5; pb_c = py_s5; end
		endcase
		in_a_c   = (pa_c >= PW'(first_low_q)) && (pa_c <= PW'(first_high_q));
		in_b_c   = (pb_c >= PW'(second_low_q)) && (pb_c <= PW'(second_high_q));
		ra_c     = pa_c - PW'(first_low_q);
		rb_c     = pb_c - PW'(second_low_q);
		span_a_c = (CW+1)'(first_high_q) - (CW+1)'(first_low_q);
		span_b_c = (CW+1)'(second_high_q) - (CW+1)'(second_low_q);
	end

	logic          vld_s6;
	logic [CW-1:0] ra_s6, rb_s6, sa_s6, sb_s6;
	logic          pos_b_s6;
	udiv_pay_t     upay_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else if (adv) vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ra_s6         <= ra_c[CW-1:0];
			rb_s6         <= rb_c[CW-1:0];
			sa_s6         <= span_a_c[CW-1:0];
			sb_s6         <= span_b_c[CW-1:0];
			pos_b_s6      <= !span_b_c[CW] && (span_b_c != '0);
			upay_s6.pos_a <= !span_a_c[CW] && (span_a_c != '0);
			upay_s6.hit   <= ok_s5 && in_a_c && in_b_c;
			upay_s6.t     <= t_s5;
			upay_s6.px    <= sat(px_s5);
			upay_s6.py    <= sat(py_s5);
			upay_s6.pz    <= sat(pz_s5);
			upay_s6.front <= front_s5;
		end
	end

	// u and v dividers run side by side
	logic            udiv_vld;
	logic [UQ_W-1:0] uq, vq;
	udiv_pay_t       udiv_pay;
	logic            vdiv_pos;

	arh_div #(.NUM_W(UQ_W), .DEN_W(CW), .payload_t(udiv_pay_t)) u_udiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s6),
		.num       ({ra_s6, {F{1'b0}}}),
		.den       (sa_s6),
		.in_pay    (upay_s6),
		.out_valid (udiv_vld),
		.quo       (uq),
		.out_pay   (udiv_pay)
	);

	arh_div #(.NUM_W(UQ_W), .DEN_W(CW), .payload_t(logic)) u_vdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s6),
		.num       ({rb_s6, {F{1'b0}}}),
		.den       (sb_s6),
		.in_pay    (pos_b_s6),
		.out_valid (),
		.quo       (vq),
		.out_pay   (vdiv_pos)
	);

	// stage 7: output register, miss clears every field
	logic            hit_s7, front_s7;
	logic [CW-1:0]   t_s7, px_s7, py_s7, pz_s7;
	logic [UV_W-1:0] u_s7, v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else if (adv) vld_s7 <= udiv_vld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s7   <= udiv_pay.hit;
			front_s7 <= udiv_pay.hit && udiv_pay.front;
			t_s7     <= udiv_pay.hit ? udiv_pay.t : '0;
			px_s7    <= udiv_pay.hit ? udiv_pay.px : '0;
			py_s7    <= udiv_pay.hit ? udiv_pay.py : '0;
			pz_s7    <= udiv_pay.hit ? udiv_pay.pz : '0;
			u_s7     <= (udiv_pay.hit && udiv_pay.pos_a) ? uq[UV_W-1:0] : '0;
			v_s7     <= (udiv_pay.hit && vdiv_pos) ? vq[UV_W-1:0] : '0;
		end
	end

	assign m_tvalid = vld_s7;
	assign m_tdata  = OUT_W'({pz_s7, py_s7, px_s7, v_s7, u_s7, t_s7});
	assign m_tuser  = {front_s7, hit_s7};

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the ray against axis-aligned rectangle hit core.
`timescale 1ns / 1ps

module tb_top;
	import arh_pkg::*;

	localparam int DUT_LATENCY = 104;
	localparam longint NEAR_RANGE = 64'sd16777216;	// keep aimed rays within +/-256.0

	// one ray, origin_x in the lowest bits
	typedef struct packed {
		logic signed [31:0] t_far;
		logic signed [31:0] t_near;
		logic signed [31:0] dir_z;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_x;
		logic signed [31:0] org_z;
		logic signed [31:0] org_y;
		logic signed [31:0] org_x;
	} ray_t;

	// one result, t_hit in the lowest bits, flags apart
	typedef struct packed {
		logic               front_facing;
		logic               hit;
		logic signed [31:0] point_z;
		logic signed [31:0] point_y;
		logic signed [31:0] point_x;
		logic        [16:0] v_coord;
		logic        [16:0] u_coord;
		logic signed [31:0] t_hit;
	} rect_hit_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [4:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [255:0] s_tdata = '0;	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_near, t_far
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [167:0] m_tdata;	// t_hit, u_coord, v_coord, point_x, point_y, point_z
	logic [1:0]   m_tuser;	// hit, front_facing

	axis_aligned_rect_ray_hit_core dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #2 clk = ~clk;

	// rectangle setup as the core should hold it
	logic [1:0] rect_axis = AXIS_XY;
	longint     rect_offset = 0;
	longint     rect_first_low = 0;
	longint     rect_first_high = 0;
	longint     rect_second_low = 0;
	longint     rect_second_high = 0;

	rect_hit_t  hits_pending[$];
	int         sender_idle_pct = 0;
	int         receiver_stall_pct = 0;
	int         mismatches = 0;
	int         rays_sent = 0;
	int         results_seen = 0;
	int         hits_seen = 0;

	function automatic longint clamp_coord(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic logic [16:0] span_fraction(longint p, longint lo, longint hi);
		longint span;
		longint q;
		span = hi - lo;
		if (span <= 0)
			return '0;
		q = ((p - lo) * 64'sd65536) / span;
		return q[16:0];
	endfunction

	// expected result of one ray against the current rectangle
	function automatic rect_hit_t predict_hit(ray_t r);
		rect_hit_t res;
		longint org[3];
		longint dir[3];
		longint pt[3];
		longint t;
		int n;
		int a;
		int b;
		res = '0;
		org[0] = r.org_x; org[1] = r.org_y; org[2] = r.org_z;
		dir[0] = r.dir_x; dir[1] = r.dir_y; dir[2] = r.dir_z;
		case (rect_axis)
			AXIS_YZ: begin n = 0; a = 1; b = 2; end
			AXIS_XZ: begin n = 1; a = 0; b = 2; end
			default: begin n = 2; a = 0; b = 1; end
		endcase
		if (dir[n] == 0)
			return res;
		t = ((rect_offset - org[n]) * 64'sd65536) / dir[n];
		if (t < longint'(r.t_near) || t > longint'(r.t_far))
			return res;
		// t now fits 32 bits, so t*dir stays inside 64
		for (int i = 0; i < 3; i++)
			pt[i] = org[i] + ((t * dir[i]) >>> 16);
		if (pt[a] < rect_first_low || pt[a] > rect_first_high ||
				pt[b] < rect_second_low || pt[b] > rect_second_high)
			return res;
		res.hit = 1'b1;
		res.t_hit = t[31:0];
		res.u_coord = span_fraction(pt[a], rect_first_low, rect_first_high);
		res.v_coord = span_fraction(pt[b], rect_second_low, rect_second_high);
		res.point_x = 32'(clamp_coord(pt[0]));
		res.point_y = 32'(clamp_coord(pt[1]));
		res.point_z = 32'(clamp_coord(pt[2]));
		res.front_facing = dir[n] < 0;
		return res;
	endfunction

	// receiver backpressure
	always @(posedge clk)
		m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);

	// result checker
	always @(posedge clk) begin
		rect_hit_t got;
		rect_hit_t want;
		if (m_tvalid && m_tready) begin
			got = {m_tuser[1], m_tuser[0], m_tdata[161:0]};
			results_seen++;
			if (got.hit)
				hits_seen++;
			if (hits_pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", got);
			end else begin
				want = hits_pending.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: exp hit=%b ff=%b t=%h u=%h v=%h p=%h/%h/%h | got hit=%b ff=%b t=%h u=%h v=%h p=%h/%h/%h",
							want.hit, want.front_facing, want.t_hit, want.u_coord,
							want.v_coord, want.point_x, want.point_y, want.point_z,
							got.hit, got.front_facing, got.t_hit, got.u_coord,
							got.v_coord, got.point_x, got.point_y, got.point_z);
				end
			end
		end
	end

	// send one ray; called at a rising edge, returns at the accepting edge
	task automatic send_ray(ray_t r);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= r;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		hits_pending.push_back(predict_hit(r));
		rays_sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (hits_pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle
	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_AXIS:        rect_axis = value[1:0];
			REG_OFFSET:      rect_offset = signed'(value);
			REG_FIRST_LOW:   rect_first_low = signed'(value);
			REG_FIRST_HIGH:  rect_first_high = signed'(value);
			REG_SECOND_LOW:  rect_second_low = signed'(value);
			REG_SECOND_HIGH: rect_second_high = signed'(value);
			default: ;
		endcase
	endtask

	task automatic set_rect(logic [1:0] axis, int offset, int f_lo, int f_hi, int s_lo, int s_hi);
		write_reg(REG_AXIS, {30'd0, axis});
		write_reg(REG_OFFSET, offset);
		write_reg(REG_FIRST_LOW, f_lo);
		write_reg(REG_FIRST_HIGH, f_hi);
		write_reg(REG_SECOND_LOW, s_lo);
		write_reg(REG_SECOND_HIGH, s_hi);
	endtask

	function automatic ray_t noise_ray();
		ray_t r;
		r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		return r;
	endfunction

	// value in [lo,hi] kept near the origin when the range allows
	function automatic longint pick_between(longint lo, longint hi);
		longint l;
		longint h;
		l = (lo > -NEAR_RANGE) ? lo : -NEAR_RANGE;
		h = (hi < NEAR_RANGE) ? hi : NEAR_RANGE;
		if (l > h)
			return lo;
		return l + $urandom_range(0, int'(h - l));
	endfunction

	// ray aimed at a point inside the current rectangle
	function automatic ray_t aimed_ray();
		ray_t r;
		longint pt[3];
		longint dir[3];
		longint org[3];
		longint t;
		longint lo;
		longint hi;
		int n;
		int a;
		int b;
		case (rect_axis)
			AXIS_YZ: begin n = 0; a = 1; b = 2; end
			AXIS_XZ: begin n = 1; a = 0; b = 2; end
			default: begin n = 2; a = 0; b = 1; end
		endcase
		pt[n] = rect_offset;
		pt[a] = pick_between(rect_first_low, rect_first_high);
		pt[b] = pick_between(rect_second_low, rect_second_high);
		t = $urandom_range(0, 32'h0040_0000);
		for (int i = 0; i < 3; i++) begin
			dir[i] = longint'($urandom_range(0, 32'h0008_0000)) - 64'sd262144;
			if (i == n && dir[i] == 0)
				dir[i] = 64'sd65536;
			org[i] = pt[i] - ((t * dir[i]) >>> 16);
		end
		r.org_x = 32'(org[0]); r.org_y = 32'(org[1]); r.org_z = 32'(org[2]);
		r.dir_x = 32'(dir[0]); r.dir_y = 32'(dir[1]); r.dir_z = 32'(dir[2]);
		case ($urandom_range(0, 3))
			0: begin lo = t; hi = t; end
			1: begin lo = t - 2; hi = t + 2; end
			2: begin lo = t + 4; hi = t + 1000; end
			default: begin lo = t - $urandom_range(0, 1 << 20); hi = t + $urandom_range(0, 1 << 20); end
		endcase
		r.t_near = 32'(lo);
		r.t_far = 32'(hi);
		return r;
	endfunction

	function automatic int rand_coord();
		return int'(longint'($urandom_range(0, 32'h0100_0000)) - 64'sd8388608);
	endfunction

	task automatic random_rect();
		int f0, f1, s0, s1;
		f0 = rand_coord(); f1 = f0 + $urandom_range(0, 32'h0080_0000);
		s0 = rand_coord(); s1 = s0 + $urandom_range(0, 32'h0080_0000);
		case ($urandom_range(0, 9))
			0: f1 = f0;	// flat on the first axis
			1: s1 = s0 - 1;	// inverted second bounds
			default: ;
		endcase
		set_rect(2'($urandom_range(0, 3)), rand_coord(), f0, f1, s0, s1);
	endtask

	// directed cases: field extremes, each axis, flat and inverted rectangles, zero normal
	task automatic test_directed();
		ray_t r;
		send_ray('0);
		send_ray({8{32'sh7fff_ffff}});
		send_ray({8{32'sh8000_0000}});
		wait_idle();
		set_rect(AXIS_XY, 32'sh0001_0000, -32'sh0002_0000, 32'sh0002_0000,
			-32'sh0002_0000, 32'sh0002_0000);
		for (int ax = 0; ax < 4; ax++) begin
			wait_idle();
			write_reg(REG_AXIS, ax);
			for (int k = 0; k < 4; k++)
				send_ray(aimed_ray());
			// another aimed ray with every direction component zeroed
			r = aimed_ray();
			r.dir_x = 0; r.dir_y = 0; r.dir_z = 0;
			send_ray(r);
		end
		wait_idle();
		write_reg(REG_FIRST_HIGH, -32'sh0002_0000);	// flat on the first axis
		send_ray(aimed_ray());
		send_ray(aimed_ray());
		wait_idle();
		write_reg(REG_SECOND_HIGH, -32'sh0003_0000);	// inverted second bounds
		send_ray(aimed_ray());
		send_ray(aimed_ray());
		wait_idle();
	endtask

	// full-range rectangles with extreme offsets
	task automatic test_extreme_rects();
		set_rect(AXIS_YZ, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
			32'sh8000_0000, 32'sh7fff_ffff);
		for (int k = 0; k < 40; k++)
			send_ray(k[0] ? aimed_ray() : noise_ray());
		wait_idle();
		set_rect(AXIS_XZ, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
			32'sh8000_0000, 32'sh7fff_ffff);
		for (int k = 0; k < 40; k++)
			send_ray(k[0] ? aimed_ray() : noise_ray());
		wait_idle();
	endtask

	// random rays under one idling pattern, rectangle changed now and then
	task automatic test_random_phase(int idle_pct, int stall_pct, int count);
		ray_t r;
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		for (int k = 0; k < count; k++) begin
			if (k % 50 == 0) begin
				wait_idle();
				random_rect();
			end
			if ($urandom_range(0, 99) < 75) begin
				r = aimed_ray();
			end else begin
				r = noise_ray();
				if ($urandom_range(0, 3) == 0) begin
					r.dir_x = 0; r.dir_y = 0; r.dir_z = 0;
				end
			end
			send_ray(r);
		end
		wait_idle();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_extreme_rects();
		test_random_phase(0, 0, 250);
		test_random_phase(85, 0, 200);
		test_random_phase(0, 85, 200);
		test_random_phase(22, 22, 250);
		test_random_phase(0, 0, 50);
		repeat (DUT_LATENCY + 20) @(posedge clk);
		$display("covered %0d rays, %0d results checked (%0d hits), all plane axes and idling phases",
			rays_sent, results_seen, hits_seen);
		if (mismatches == 0 && hits_pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
